@@ rtl/fsd_pkg.sv @@
// ----------------------------------------------------------------------------
// fsd_pkg: shared types and constants for the fair-share task dispatcher
// Slot record layout, stream item layouts, status codes, slice lookup.
// ----------------------------------------------------------------------------
package fsd_pkg;

  localparam int MAX_TASKS_DEF = 16;

  localparam int TIME_W = 24;
  localparam int VR_W   = 48;
  localparam int PRIO_W = 8;
  localparam int BURST_W = 16;
  localparam int WEIGHT_W = 6;
  localparam int PROD_W = BURST_W + WEIGHT_W;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [VR_W-1:0]   VR_MAX   = '1;

  localparam logic [PRIO_W-1:0] PRIO_BASE  = 8'd120;
  localparam logic [PRIO_W-1:0] PRIO_PIVOT = 8'd140;

  localparam logic [2:0] ST_DISPATCHED = 3'd0;
  localparam logic [2:0] ST_ADDED      = 3'd1;
  localparam logic [2:0] ST_REJECTED   = 3'd2;
  localparam logic [2:0] ST_EMPTY      = 3'd3;
  localparam logic [2:0] ST_LIMIT      = 3'd4;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  typedef struct packed {
    logic [VR_W-1:0]    vruntime;
    logic [PRIO_W-1:0]  priority_lvl;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic               started;
  } slot_rec_t;

  typedef struct packed {
    logic [VR_W-1:0]   vruntime;
    logic [PRIO_W-1:0] priority_lvl;
    logic [TIME_W-1:0] arrival;
  } order_key_t;

  typedef struct packed {
    logic clear;
    logic offer;
  } pick_ctl_t;

  // input tdata, lowest field last
  typedef struct packed {
    logic [5:0]         pad;
    logic [5:0]         nice_value;
    logic [BURST_W-1:0] burst_length;
    logic [TIME_W-1:0]  arrival_time;
    logic [3:0]         task_id;
  } in_item_t;

  // output tdata, lowest field last
  typedef struct packed {
    logic [6:0]        pad;
    logic [VR_W-1:0]   new_vruntime;
    logic [TIME_W-1:0] completion_time;
    logic              finished;
    logic [TIME_W-1:0] response_time;
    logic              first_run;
    logic [2:0]        run_length;
    logic [TIME_W-1:0] start_time;
    logic [3:0]        run_task;
  } out_item_t;

  function automatic logic [2:0] slice_len(input logic [PRIO_W-1:0] prio);
    logic [2:0] sl;
    if (prio inside {[8'd100:8'd109]}) begin
      sl = 3'd4;
    end else if (prio inside {[8'd110:8'd119]}) begin
      sl = 3'd3;
    end else if (prio inside {[8'd120:8'd129]}) begin
      sl = 3'd2;
    end else begin
      sl = 3'd1;
    end
    return sl;
  endfunction

endpackage

@@ rtl/fair_share_task_dispatcher.sv @@
// ----------------------------------------------------------------------------
// fair_share_task_dispatcher: fair-share task table and slice dispatcher
//
//   channel   dir   handshake                     payload
//   s_axis    in    s_axis_tvalid/s_axis_tready   tuser: operation, tdata: task
//   m_axis    out   m_axis_tvalid/m_axis_tready   tuser: status, tdata: result
//   cfg       in    cfg_we                        cfg_wdata: time_limit
//
// Add item: decided in the idle state and passed on through S_DONE. Dispatch
// item: two serial scans of the slot RAM through its single read port plus
// a three-step slice/vruntime update. One item in flight at a time.
// Reset clears slot valid bits and current time; time_limit resets to max.
// A finished result sits in the output register; the next item is accepted
// while it waits, and a later result holds until that register frees up.
// ----------------------------------------------------------------------------
module fair_share_task_dispatcher #(
  parameter int MAX_TASKS = fsd_pkg::MAX_TASKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // task_id[3:0], arrival_time[27:4], burst_length[43:28], nice_value[49:44]
  input  logic [55:0]                s_axis_tdata,
  // operation[0]
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // run_task[3:0], start_time[27:4], run_length[30:28], first_run[31],
  // response_time[55:32], finished[56], completion_time[80:57],
  // new_vruntime[128:81]
  output logic [135:0]               m_axis_tdata,
  // status[2:0]
  output logic [2:0]                 m_axis_tuser,
  input  logic                       cfg_we,
  input  logic [fsd_pkg::TIME_W-1:0] cfg_wdata
);
  import fsd_pkg::*;

  localparam int IW = $clog2(MAX_TASKS);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN_A = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_SCAN_B = 4'd3;
  localparam logic [3:0] S_READ   = 4'd4;
  localparam logic [3:0] S_CALC1  = 4'd5;
  localparam logic [3:0] S_CALC2  = 4'd6;
  localparam logic [3:0] S_CALC3  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]           state;
  logic [IW-1:0]        cnt;
  logic                 scan_issue;
  logic                 rd_valid;
  logic [IW-1:0]        rd_idx;
  logic                 any_valid;
  logic [TIME_W-1:0]    earliest;
  logic [TIME_W-1:0]    now_time;
  logic [TIME_W-1:0]    time_limit;
  logic [MAX_TASKS-1:0] valid;

  slot_rec_t            cur;
  logic [2:0]           run_len;
  logic [BURST_W-1:0]   rem_new;
  logic [TIME_W-1:0]    after;
  logic [PROD_W-1:0]    prod;

  logic [2:0]           res_status;
  out_item_t            res_data;
  logic [2:0]           out_status;
  out_item_t            out_data;
  logic                 out_valid;

  in_item_t             item;
  logic                 in_fire;
  logic                 id_ok;
  logic [IW-1:0]        id_idx;
  logic [PRIO_W-1:0]    add_prio;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  slot_rec_t            ram_wdata;
  logic [IW-1:0]        ram_raddr;
  slot_rec_t            rd_rec;

  pick_ctl_t            pick_ctl;
  order_key_t           pick_key;
  logic [IW-1:0]        best_idx;

  logic [2:0]           sl;
  logic [2:0]           run_calc;
  logic [TIME_W:0]      after_sum;
  logic [BURST_W-1:0]   cpu;
  logic [WEIGHT_W-1:0]  weight;
  logic [VR_W:0]        vr_sum;
  logic [VR_W-1:0]      prod_ext;
  logic [VR_W-1:0]      vr_next;
  logic                 out_free;

  assign item          = in_item_t'(s_axis_tdata);
  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign id_ok         = 32'(item.task_id) < MAX_TASKS;
  assign id_idx        = IW'(item.task_id);
  assign add_prio      = PRIO_BASE + {{2{item.nice_value[5]}}, item.nice_value};
  assign out_free      = !out_valid || m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_status;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = id_idx;
    ram_wdata = '{vruntime: '0, priority_lvl: add_prio, arrival: item.arrival_time,
                  burst: item.burst_length, remaining: item.burst_length,
                  started: 1'b0};
    if (state == S_IDLE) begin
      ram_we = in_fire && (s_axis_tuser == OP_ADD) && id_ok && !valid[id_idx];
    end else if (state == S_CALC3) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx;
      ram_wdata = '{vruntime: vr_next, priority_lvl: cur.priority_lvl,
                    arrival: cur.arrival, burst: cur.burst, remaining: rem_new,
                    started: 1'b1};
    end
  end

  assign ram_raddr = (state == S_SCAN_A || state == S_SCAN_B) ? cnt : best_idx;

  fsd_ram #(
    .WIDTH ($bits(slot_rec_t)),
    .DEPTH (MAX_TASKS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_rec)
  );

  assign pick_ctl.clear = (state == S_CHECK);
  assign pick_ctl.offer = (state == S_SCAN_B) && rd_valid && valid[rd_idx] &&
                          (rd_rec.arrival <= now_time);
  assign pick_key = '{vruntime: rd_rec.vruntime, priority_lvl: rd_rec.priority_lvl,
                      arrival: rd_rec.arrival};

  fsd_pick #(
    .IW (IW)
  ) u_pick (
    .clk      (clk),
    .rst      (rst),
    .ctl      (pick_ctl),
    .cand     (pick_key),
    .cand_idx (rd_idx),
    .best_idx (best_idx)
  );

  // slice length and time after the slice, from the freshly read record
  always_comb begin
    sl        = slice_len(rd_rec.priority_lvl);
    run_calc  = (rd_rec.remaining < BURST_W'(sl)) ? rd_rec.remaining[2:0] : sl;
    after_sum = {1'b0, now_time} + (TIME_W+1)'(run_calc);
  end

  // vruntime weight and update
  always_comb begin
    cpu      = cur.burst - rem_new;
    weight   = (cur.priority_lvl <= PRIO_PIVOT) ?
               WEIGHT_W'(PRIO_PIVOT - cur.priority_lvl) :
               WEIGHT_W'(cur.priority_lvl - PRIO_PIVOT);
    prod_ext = VR_W'(prod);
    vr_sum   = {1'b0, cur.vruntime} + {1'b0, prod_ext};
    if (cur.priority_lvl <= PRIO_PIVOT) begin
      vr_next = vr_sum[VR_W] ? VR_MAX : vr_sum[VR_W-1:0];
    end else begin
      vr_next = (prod_ext >= cur.vruntime) ? '0 : cur.vruntime - prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_issue <= 1'b0;
      rd_valid   <= 1'b0;
      now_time   <= '0;
      time_limit <= TIME_MAX;
      valid      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        time_limit <= cfg_wdata;
      end

      rd_valid <= (state == S_SCAN_A || state == S_SCAN_B) && scan_issue;
      rd_idx   <= cnt;
      if ((state == S_SCAN_A || state == S_SCAN_B) && scan_issue) begin
        if (cnt == LAST_IDX) begin
          scan_issue <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end

      if (out_valid && m_axis_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_data <= '0;
            if (s_axis_tuser == OP_ADD) begin
              if (!id_ok || valid[id_idx]) begin
                res_status <= ST_REJECTED;
              end else begin
                res_status     <= ST_ADDED;
                valid[id_idx]  <= 1'b1;
              end
              state <= S_DONE;
            end else if (now_time >= time_limit) begin
              res_status <= ST_LIMIT;
              state      <= S_DONE;
            end else begin
              cnt        <= '0;
              scan_issue <= 1'b1;
              any_valid  <= 1'b0;
              earliest   <= TIME_MAX;
              state      <= S_SCAN_A;
            end
          end
        end
        S_SCAN_A: begin
          if (rd_valid && valid[rd_idx]) begin
            any_valid <= 1'b1;
            if (rd_rec.arrival < earliest) begin
              earliest <= rd_rec.arrival;
            end
          end
          if (rd_valid && rd_idx == LAST_IDX) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!any_valid) begin
            res_status <= ST_EMPTY;
            state      <= S_DONE;
          end else if (earliest > now_time && earliest >= time_limit) begin
            now_time   <= earliest;
            res_status <= ST_LIMIT;
            state      <= S_DONE;
          end else begin
            if (earliest > now_time) begin
              now_time <= earliest;
            end
            cnt        <= '0;
            scan_issue <= 1'b1;
            state      <= S_SCAN_B;
          end
        end
        S_SCAN_B: begin
          if (rd_valid && rd_idx == LAST_IDX) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CALC1;
        end
        S_CALC1: begin
          cur     <= rd_rec;
          run_len <= run_calc;
          rem_new <= rd_rec.remaining - BURST_W'(run_calc);
          after   <= after_sum[TIME_W] ? TIME_MAX : after_sum[TIME_W-1:0];
          state   <= S_CALC2;
        end
        S_CALC2: begin
          prod  <= {{WEIGHT_W{1'b0}}, cpu} * {{BURST_W{1'b0}}, weight};
          state <= S_CALC3;
        end
        S_CALC3: begin
          res_status               <= ST_DISPATCHED;
          res_data.pad             <= '0;
          res_data.run_task        <= 4'(best_idx);
          res_data.start_time      <= now_time;
          res_data.run_length      <= run_len;
          res_data.first_run       <= !cur.started;
          res_data.response_time   <= cur.started ? '0 : now_time - cur.arrival;
          res_data.finished        <= (rem_new == '0);
          res_data.completion_time <= after;
          res_data.new_vruntime    <= vr_next;
          now_time                 <= after;
          if (rem_new == '0) begin
            valid[best_idx] <= 1'b0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_data   <= res_data;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/fsd_ram.sv @@
// ----------------------------------------------------------------------------
// fsd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/fsd_pick.sv @@
// ----------------------------------------------------------------------------
// fsd_pick: running best-candidate compare unit
// Keeps the earliest-ordered slot seen during a scan: lower vruntime, then
// lower priority, then earlier arrival; ascending scan keeps the lower id.
// ----------------------------------------------------------------------------
module fsd_pick #(
  parameter int IW = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fsd_pkg::pick_ctl_t         ctl,
  input  fsd_pkg::order_key_t        cand,
  input  logic [IW-1:0]              cand_idx,
  output logic [IW-1:0]              best_idx
);
  import fsd_pkg::*;

  logic       have;
  order_key_t best;
  logic       cand_first;

  always_comb begin
    if (cand.vruntime != best.vruntime) begin
      cand_first = cand.vruntime < best.vruntime;
    end else if (cand.priority_lvl != best.priority_lvl) begin
      cand_first = cand.priority_lvl < best.priority_lvl;
    end else begin
      cand_first = cand.arrival < best.arrival;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (ctl.clear) begin
      have <= 1'b0;
    end else if (ctl.offer) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.offer && !ctl.clear && (!have || cand_first)) begin
      best     <= cand;
      best_idx <= cand_idx;
    end
  end

endmodule

@@ tb/fair_share_task_dispatcher_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fair_share_task_dispatcher_test: self-checking bench for the task dispatcher
// Drives add and dispatch items over the input stream and keeps its own copy
// of the task table, current time and time limit. Every result is checked
// field by field in order. A directed opener covers the limit, empty-table,
// late-arrival, zero-burst, busy-slot and tie-break cases. Random phases
// follow under several time limits, with bursty input, a stalling output
// and one long output hold. The run closes by saturating the time counter.
// ----------------------------------------------------------------------------
module fair_share_task_dispatcher_test;
  import fsd_pkg::*;

  localparam int SLOTS = MAX_TASKS_DEF;

  typedef struct {
    logic [2:0] status;
    out_item_t  data;
  } result_t;

  class dispatch_scoreboard;
    logic [TIME_W-1:0]  limit;
    logic [TIME_W-1:0]  now;
    logic               in_use  [SLOTS];
    logic [VR_W-1:0]    vrt     [SLOTS];
    logic [PRIO_W-1:0]  prio    [SLOTS];
    logic [TIME_W-1:0]  arrive  [SLOTS];
    logic [BURST_W-1:0] need    [SLOTS];
    logic [BURST_W-1:0] owed    [SLOTS];
    logic               ran     [SLOTS];
    result_t            due_results[$];
    int                 errors;
    int                 status_count[5];

    function new();
      limit = TIME_MAX;
      now = '0;
      errors = 0;
      foreach (in_use[i]) in_use[i] = 1'b0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function int busy_slots();
      int n;
      n = 0;
      foreach (in_use[i]) if (in_use[i]) n++;
      return n;
    endfunction

    function bit ahead_of(int a, int b);
      if (vrt[a] != vrt[b]) return vrt[a] < vrt[b];
      if (prio[a] != prio[b]) return prio[a] < prio[b];
      if (arrive[a] != arrive[b]) return arrive[a] < arrive[b];
      return a < b;
    endfunction

    function void note_item(logic op, in_item_t it);
      result_t            r;
      logic [TIME_W-1:0]  earliest;
      logic [TIME_W-1:0]  start;
      logic [TIME_W:0]    sum;
      logic [2:0]         slice;
      logic [2:0]         run;
      logic [BURST_W-1:0] cpu;
      longint unsigned    acc;
      int                 pick;
      bit                 any;
      r.status = ST_DISPATCHED;
      r.data = '0;
      if (op == OP_ADD) begin
        if (in_use[it.task_id]) begin
          r.status = ST_REJECTED;
        end else begin
          in_use[it.task_id] = 1'b1;
          vrt[it.task_id] = '0;
          prio[it.task_id] = PRIO_BASE + {{2{it.nice_value[5]}}, it.nice_value};
          arrive[it.task_id] = it.arrival_time;
          need[it.task_id] = it.burst_length;
          owed[it.task_id] = it.burst_length;
          ran[it.task_id] = 1'b0;
          r.status = ST_ADDED;
        end
      end else if (now >= limit) begin
        r.status = ST_LIMIT;
      end else begin
        any = 0;
        earliest = TIME_MAX;
        foreach (in_use[i]) begin
          if (in_use[i]) begin
            any = 1;
            if (arrive[i] < earliest) earliest = arrive[i];
          end
        end
        if (!any) begin
          r.status = ST_EMPTY;
        end else begin
          if (earliest > now) now = earliest;
          if (now >= limit) begin
            r.status = ST_LIMIT;
          end else begin
            pick = -1;
            foreach (in_use[i]) begin
              if (in_use[i] && arrive[i] <= now) begin
                if (pick < 0 || ahead_of(i, pick)) pick = i;
              end
            end
            start = now;
            if (prio[pick] >= 100 && prio[pick] <= 109) begin
              slice = 3'd4;
            end else if (prio[pick] >= 110 && prio[pick] <= 119) begin
              slice = 3'd3;
            end else if (prio[pick] >= 120 && prio[pick] <= 129) begin
              slice = 3'd2;
            end else begin
              slice = 3'd1;
            end
            run = (owed[pick] < slice) ? owed[pick][2:0] : slice;
            sum = {1'b0, start} + run;
            now = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            owed[pick] = owed[pick] - run;
            cpu = need[pick] - owed[pick];
            if (prio[pick] <= PRIO_PIVOT) begin
              acc = vrt[pick] + longint'(cpu) * longint'(PRIO_PIVOT - prio[pick]);
              vrt[pick] = (acc > VR_MAX) ? VR_MAX : acc[VR_W-1:0];
            end else begin
              acc = longint'(cpu) * longint'(prio[pick] - PRIO_PIVOT);
              vrt[pick] = (acc >= vrt[pick]) ? '0 : vrt[pick] - acc[VR_W-1:0];
            end
            r.data.run_task = pick[3:0];
            r.data.start_time = start;
            r.data.run_length = run;
            r.data.first_run = !ran[pick];
            r.data.response_time = ran[pick] ? '0 : start - arrive[pick];
            r.data.finished = (owed[pick] == 0);
            r.data.completion_time = now;
            r.data.new_vruntime = vrt[pick];
            ran[pick] = 1'b1;
            if (owed[pick] == 0) in_use[pick] = 1'b0;
          end
        end
      end
      status_count[r.status]++;
      due_results = {due_results, r};
    endfunction

    function void check_field(string name, logic [VR_W-1:0] want, logic [VR_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [2:0] st, out_item_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d, data 0x%0h", $time, st, got);
        return;
      end
      want = due_results.pop_front();
      check_field("status", want.status, st);
      check_field("run_task", want.data.run_task, got.run_task);
      check_field("start_time", want.data.start_time, got.start_time);
      check_field("run_length", want.data.run_length, got.run_length);
      check_field("first_run", want.data.first_run, got.first_run);
      check_field("response_time", want.data.response_time, got.response_time);
      check_field("finished", want.data.finished, got.finished);
      check_field("completion_time", want.data.completion_time, got.completion_time);
      check_field("new_vruntime", want.data.new_vruntime, got.new_vruntime);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [55:0]        s_axis_tdata;   // task_id, arrival_time, burst_length, nice_value
  logic               s_axis_tuser;   // operation
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [135:0]       m_axis_tdata;   // run_task, start_time, run_length, first_run,
                                      // response_time, finished, completion_time,
                                      // new_vruntime
  logic [2:0]         m_axis_tuser;   // status
  logic               cfg_we;
  logic [TIME_W-1:0]  cfg_wdata;

  dispatch_scoreboard tracker;
  int                 items_sent = 0;
  int                 adds_sent = 0;
  int                 limit_writes = 0;
  int                 results_seen = 0;
  int                 hold_left = 0;
  bit                 hold_done = 0;
  int                 rx_mode = 0;
  int                 mode_left = 0;

  fair_share_task_dispatcher uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("** fair_share_task_dispatcher: FAILED **");
    $finish;
  end

  // result side: check, then choose the next ready value
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_result(m_axis_tuser, m_axis_tdata);
        results_seen++;
      end
      if (!hold_done && results_seen == 200) begin
        hold_left = 500;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic op, input in_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it;
    s_axis_tuser <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.note_item(op, it);
    items_sent++;
    if (op == OP_ADD) adds_sent++;
  endtask

  task automatic send_add(input logic [3:0] id, input logic [TIME_W-1:0] arr,
                          input logic [BURST_W-1:0] burst, input logic [5:0] nice);
    in_item_t it;
    it = '0;
    it.task_id = id;
    it.arrival_time = arr;
    it.burst_length = burst;
    it.nice_value = nice;
    send_item(OP_ADD, it);
  endtask

  task automatic send_dispatch();
    in_item_t it;
    it = 56'({$urandom(), $urandom()});
    it.pad = '0;
    send_item(OP_DISPATCH, it);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic write_limit(input logic [TIME_W-1:0] value);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.limit = value;
    limit_writes++;
  endtask

  function automatic logic [TIME_W-1:0] later(input int unsigned delta);
    logic [TIME_W:0] sum;
    sum = {1'b0, tracker.now} + (TIME_W+1)'(delta);
    return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  // mostly well-formed adds into free slots near the current time; some adds
  // with random content hit busy slots
  function automatic void make_item(output logic op, output in_item_t it);
    int   free_ids[$];
    int   busy_ids[$];
    int   roll;
    int   nv;
    it = 56'({$urandom(), $urandom()});
    it.pad = '0;
    foreach (tracker.in_use[i]) begin
      if (tracker.in_use[i]) busy_ids = {busy_ids, i};
      else free_ids = {free_ids, i};
    end
    roll = $urandom_range(0, 99);
    if (busy_ids.size() < 4) op = (roll < 70) ? OP_ADD : OP_DISPATCH;
    else if (busy_ids.size() > 12) op = (roll < 20) ? OP_ADD : OP_DISPATCH;
    else op = (roll < 45) ? OP_ADD : OP_DISPATCH;
    if (op == OP_DISPATCH) return;
    if (busy_ids.size() > 0 && (free_ids.size() == 0 || $urandom_range(0, 9) == 0)) begin
      it.task_id = 4'(busy_ids[$urandom_range(0, busy_ids.size() - 1)]);
      return;
    end
    it.task_id = 4'(free_ids[$urandom_range(0, free_ids.size() - 1)]);
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      it.arrival_time = TIME_W'(tracker.now -
                        $urandom_range(0, (tracker.now < 50) ? tracker.now : 50));
    end else if (roll < 90) begin
      it.arrival_time = later($urandom_range(1, 30));
    end else begin
      it.arrival_time = later($urandom_range(31, 3000));
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) it.burst_length = BURST_W'($urandom_range(0, 12));
    else if (roll < 95) it.burst_length = BURST_W'($urandom_range(13, 40));
    else it.burst_length = BURST_W'($urandom_range(41, 60));
    if ($urandom_range(0, 99) < 85) begin
      nv = $urandom_range(0, 39) - 20;
      it.nice_value = nv[5:0];
    end
  endfunction

  task automatic run_phase(input int count);
    int       left;
    int       burst_len;
    int       gap;
    logic     op;
    in_item_t it;
    left = count;
    while (left > 0) begin
      burst_len = $urandom_range(1, 24);
      while (burst_len > 0 && left > 0) begin
        make_item(op, it);
        send_item(op, it);
        burst_len--;
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_ADD;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // limit of zero: every dispatch stops at the limit
    write_limit('0);
    send_dispatch();
    send_add(4'd7, 24'd3, 16'd2, 6'd0);
    send_dispatch();
    wait_idle();

    // late arrival jump, empty table, zero burst, busy slot, jump past limit
    write_limit(24'd1000);
    send_dispatch();
    send_dispatch();
    send_add(4'd0, 24'd0, 16'd0, 6'd0);
    send_dispatch();
    send_add(4'd5, 24'd2000, 16'd4, -6'sd10);
    send_add(4'd5, 24'd2000, 16'd4, -6'sd10);
    send_dispatch();
    wait_idle();

    // nice extremes and weight below zero, with vruntime ties broken by priority
    write_limit(24'd3000);
    send_add(4'd1, 24'd2000, 16'd3, 6'd19);
    send_add(4'd2, 24'd2001, 16'd5, -6'sd32);
    send_add(4'd3, 24'd2000, 16'd6, 6'd31);
    send_add(4'd4, 24'd2010, 16'd2, -6'sd20);
    send_add(4'd6, 24'd2000, 16'd4, -6'sd10);
    repeat (8) send_dispatch();
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_limit(later($urandom_range(300, 900)));
        1: write_limit(TIME_MAX);
        2: write_limit(later($urandom_range(100, 400)));
        default: write_limit(TIME_W'(TIME_MAX - 1));
      endcase
      run_phase(410);
      wait_idle();
    end

    // empty the table, then push time to its ceiling
    write_limit(TIME_MAX);
    while (tracker.busy_slots() > 0) send_dispatch();
    send_add(4'd10, TIME_W'(TIME_MAX - 2), 16'hFFFF, 6'd31);
    send_add(4'd9, TIME_W'(TIME_MAX - 1), 16'hFFFF, -6'sd20);
    repeat (3) send_dispatch();
    wait_idle();
    repeat (60) @(posedge clk);

    $display("Run covered %0d items (%0d adds) under %0d time limits, ending at time 0x%0h.",
             items_sent, adds_sent, limit_writes, tracker.now);
    $display("Results: %0d dispatched, %0d added, %0d rejected, %0d empty, %0d at limit.",
             tracker.status_count[ST_DISPATCHED], tracker.status_count[ST_ADDED],
             tracker.status_count[ST_REJECTED], tracker.status_count[ST_EMPTY],
             tracker.status_count[ST_LIMIT]);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("** fair_share_task_dispatcher: PASSED **");
    end else begin
      $display("** fair_share_task_dispatcher: FAILED **");
    end
    $finish;
  end

endmodule
